// ===== rtl/bitmap_priority_task_scheduler_defines.svh =====
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Shared property shapes for the scheduler checker, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PRIORITY_TASK_SCHEDULER_DEFINES_SVH
`define BITMAP_PRIORITY_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, masked while reset is active
`define BPTS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("scheduler check failed");

// Next-cycle implication, masked while reset is active
`define BPTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("scheduler check failed");

// Next-cycle implication that also holds across reset
`define BPTS_ASSERT_NEXT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) \
        (ante) |=> (cons)) else $error("scheduler reset check failed");

`endif

// ===== rtl/bpts_pkg.sv =====
// ----------------------------------------------------------------------------
// bpts_pkg
// Sizes, codes and shared types of the bitmap priority task scheduler.
// ----------------------------------------------------------------------------
package bpts_pkg;

    localparam int NUM_LEVELS = 32;
    localparam int NUM_TASKS  = 64;
    localparam int LVL_W      = $clog2(NUM_LEVELS);
    localparam int SLOT_W     = $clog2(NUM_TASKS);

    // Field widths of the channels
    localparam int OP_W   = 3;
    localparam int TASK_W = 6;
    localparam int PRIO_W = 6;
    localparam int CFG_W  = 5;

    localparam logic [CFG_W-1:0] DEFAULT_PRIO_RST = 5'd16;

    // Event codes
    localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd1;
    localparam logic [OP_W-1:0] OP_BLOCK   = 3'd2;
    localparam logic [OP_W-1:0] OP_UNBLOCK = 3'd3;
    localparam logic [OP_W-1:0] OP_EXIT    = 3'd4;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_BLOCKED = 2'd3
    } t_slot_state;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_SLOT,
        S_CHECK,
        S_EQ_RD,
        S_EQ_WR,
        S_DQ_SEL,
        S_DQ_HEAD,
        S_DQ_LINK,
        S_DONE
    } t_seq_state;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TASK_W-1:0] task_slot;
        logic [PRIO_W-1:0] prio;
    } t_in_item;

    typedef struct packed {
        logic [TASK_W-1:0] running_task;
        logic              running_idle;
        logic              switched;
        logic              status;
    } t_result;

    // Slot memory port: one read, one write with per-field enables
    typedef struct packed {
        logic              re;
        logic [SLOT_W-1:0] raddr;
        logic              we_next;
        logic              we_prio;
        logic              we_state;
        logic [SLOT_W-1:0] waddr;
        logic [SLOT_W-1:0] wnext;
        logic [LVL_W-1:0]  wprio;
        t_slot_state       wstate;
    } t_slot_req;

    typedef struct packed {
        logic [SLOT_W-1:0] next;
        logic [LVL_W-1:0]  prio;
        t_slot_state       state;
    } t_slot_rsp;

    // Queue memory port: head and tail per level
    typedef struct packed {
        logic              re;
        logic [LVL_W-1:0]  raddr;
        logic              we;
        logic [LVL_W-1:0]  waddr;
        logic [SLOT_W-1:0] whead;
        logic [SLOT_W-1:0] wtail;
    } t_q_req;

    typedef struct packed {
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
    } t_q_rsp;

endpackage

// ===== rtl/bpts_slot_ram.sv =====
// ----------------------------------------------------------------------------
// bpts_slot_ram
// Per-slot link, priority and state memory with registered read data.
// ----------------------------------------------------------------------------
module bpts_slot_ram import bpts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_slot_req i_req,
    output t_slot_rsp o_rsp
);

    logic [SLOT_W-1:0]    r_next_mem  [NUM_TASKS];
    logic [LVL_W-1:0]     r_prio_mem  [NUM_TASKS];
    t_slot_state          r_state_mem [NUM_TASKS];
    logic [NUM_TASKS-1:0] r_state_vld;
    t_slot_rsp            r_rd;

    // Array writes and registered read (read-first)
    always_ff @(posedge i_clk) begin
        if (i_req.we_next) begin
            r_next_mem[i_req.waddr] <= i_req.wnext;
        end
        if (i_req.we_prio) begin
            r_prio_mem[i_req.waddr] <= i_req.wprio;
        end
        if (i_req.we_state) begin
            r_state_mem[i_req.waddr] <= i_req.wstate;
        end
        if (i_req.re) begin
            r_rd.next  <= r_next_mem[i_req.raddr];
            r_rd.prio  <= r_prio_mem[i_req.raddr];
            r_rd.state <= r_state_vld[i_req.raddr] ? r_state_mem[i_req.raddr] : ST_FREE;
        end
    end

    // State valid bits: an unwritten slot reads as free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_vld <= '0;
        end else if (i_req.we_state) begin
            r_state_vld[i_req.waddr] <= 1'b1;
        end
    end

    assign o_rsp = r_rd;

endmodule

// ===== rtl/bpts_queue_ram.sv =====
// ----------------------------------------------------------------------------
// bpts_queue_ram
// Head and tail slot of each priority level's run queue.
// ----------------------------------------------------------------------------
module bpts_queue_ram import bpts_pkg::*; (
    input  logic   i_clk,
    input  t_q_req i_req,
    output t_q_rsp o_rsp
);

    logic [SLOT_W-1:0] r_head_mem [NUM_LEVELS];
    logic [SLOT_W-1:0] r_tail_mem [NUM_LEVELS];
    t_q_rsp            r_rd;

    // Word write and registered read (read-first)
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_head_mem[i_req.waddr] <= i_req.whead;
            r_tail_mem[i_req.waddr] <= i_req.wtail;
        end
        if (i_req.re) begin
            r_rd.head <= r_head_mem[i_req.raddr];
            r_rd.tail <= r_tail_mem[i_req.raddr];
        end
    end

    assign o_rsp = r_rd;

endmodule

// ===== rtl/bpts_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpts_ctrl
// Event sequencer: checks, enqueue and dequeue passes over the two memories,
// level bitmap, current task and default priority register.
// ----------------------------------------------------------------------------
module bpts_ctrl import bpts_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in_item         i_item,
    input  logic             i_out_free,
    output logic             o_done,
    output t_result          o_result,
    output t_slot_req        o_slot_req,
    input  t_slot_rsp        i_slot_rsp,
    output t_q_req           o_q_req,
    input  t_q_rsp           i_q_rsp
);

    t_seq_state            r_state, n_state;
    t_in_item              r_item, n_item;
    logic [SLOT_W-1:0]     r_cur_slot, n_cur_slot;
    logic                  r_cur_idle, n_cur_idle;
    logic [SLOT_W-1:0]     r_was_slot, n_was_slot;
    logic                  r_was_idle, n_was_idle;
    logic [NUM_LEVELS-1:0] r_bitmap, n_bitmap;
    logic [CFG_W-1:0]      r_dflt;
    logic                  r_status, n_status;
    logic [SLOT_W-1:0]     r_eslot, n_eslot;
    logic [LVL_W-1:0]      r_elvl, n_elvl;
    logic [LVL_W-1:0]      r_dlvl, n_dlvl;
    logic [SLOT_W-1:0]     r_head, n_head;
    logic [SLOT_W-1:0]     r_qtail, n_qtail;

    logic                  slot_in_range;
    logic                  create_ok;
    logic                  unblock_ok;
    logic                  cur_running;
    logic                  exit_ok;
    logic [SLOT_W-1:0]     item_slot;

    // Level for a requested priority; out-of-range falls back to the default
    function automatic logic [LVL_W-1:0] level_for(input logic [PRIO_W-1:0] p,
                                                    input logic [CFG_W-1:0]  d);
        logic [LVL_W-1:0] lv;
        if (int'(p) < NUM_LEVELS) begin
            lv = LVL_W'(p);
        end else if (int'(d) < NUM_LEVELS) begin
            lv = LVL_W'(d);
        end else begin
            lv = LVL_W'(NUM_LEVELS - 1);
        end
        return lv;
    endfunction

    // Lowest set bit of the bitmap (highest non-empty priority)
    function automatic logic [LVL_W-1:0] lowest_level(input logic [NUM_LEVELS-1:0] bm);
        logic [LVL_W-1:0] idx;
        idx = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (bm[i]) begin
                idx = LVL_W'(i);
            end
        end
        return idx;
    endfunction

    // Checks on the slot word read in the previous cycle
    assign item_slot     = SLOT_W'(r_item.task_slot);
    assign slot_in_range = int'(r_item.task_slot) < NUM_TASKS;
    assign create_ok     = slot_in_range && (i_slot_rsp.state == ST_FREE);
    assign unblock_ok    = slot_in_range && (i_slot_rsp.state == ST_BLOCKED);
    assign cur_running   = !r_cur_idle && (i_slot_rsp.state == ST_RUNNING);
    assign exit_ok       = !r_cur_idle && ((i_slot_rsp.state == ST_RUNNING) ||
                                           (i_slot_rsp.state == ST_BLOCKED));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_RD_SLOT;
                end
            end
            S_RD_SLOT: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                unique case (r_item.op)
                    OP_CREATE:  n_state = create_ok ? S_EQ_RD : S_DONE;
                    OP_UNBLOCK: n_state = unblock_ok ? S_EQ_RD : S_DONE;
                    OP_TICK:    n_state = cur_running ? S_EQ_RD : S_DQ_SEL;
                    default:    n_state = S_DONE;
                endcase
            end
            S_EQ_RD: begin
                n_state = S_EQ_WR;
            end
            S_EQ_WR: begin
                n_state = (r_item.op == OP_TICK) ? S_DQ_SEL : S_DONE;
            end
            S_DQ_SEL: begin
                n_state = (r_bitmap == '0) ? S_DONE : S_DQ_HEAD;
            end
            S_DQ_HEAD: begin
                n_state = (i_q_rsp.head == i_q_rsp.tail) ? S_DONE : S_DQ_LINK;
            end
            S_DQ_LINK: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs: memory requests and datapath updates
    always_comb begin
        n_item     = r_item;
        n_cur_slot = r_cur_slot;
        n_cur_idle = r_cur_idle;
        n_was_slot = r_was_slot;
        n_was_idle = r_was_idle;
        n_bitmap   = r_bitmap;
        n_status   = r_status;
        n_eslot    = r_eslot;
        n_elvl     = r_elvl;
        n_dlvl     = r_dlvl;
        n_head     = r_head;
        n_qtail    = r_qtail;
        o_slot_req = '0;
        o_q_req    = '0;
        o_done     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_item     = i_item;
                    n_was_slot = r_cur_slot;
                    n_was_idle = r_cur_idle;
                    n_status   = 1'b0;
                end
            end
            S_RD_SLOT: begin
                o_slot_req.re    = 1'b1;
                o_slot_req.raddr = ((r_item.op == OP_CREATE) || (r_item.op == OP_UNBLOCK)) ?
                                   item_slot : r_cur_slot;
            end
            S_CHECK: begin
                unique case (r_item.op)
                    OP_CREATE: begin
                        n_eslot  = item_slot;
                        n_elvl   = level_for(r_item.prio, r_dflt);
                        n_status = !create_ok;
                    end
                    OP_UNBLOCK: begin
                        n_eslot  = item_slot;
                        n_elvl   = i_slot_rsp.prio;
                        n_status = !unblock_ok;
                    end
                    OP_TICK: begin
                        // requeue a running current task at its own level
                        n_eslot = r_cur_slot;
                        n_elvl  = i_slot_rsp.prio;
                    end
                    OP_BLOCK: begin
                        n_status            = !cur_running;
                        o_slot_req.we_state = cur_running;
                        o_slot_req.waddr    = r_cur_slot;
                        o_slot_req.wstate   = ST_BLOCKED;
                    end
                    OP_EXIT: begin
                        n_status            = !exit_ok;
                        o_slot_req.we_state = exit_ok;
                        o_slot_req.waddr    = r_cur_slot;
                        o_slot_req.wstate   = ST_FREE;
                    end
                    default: begin
                        n_status = 1'b1;
                    end
                endcase
            end
            S_EQ_RD: begin
                o_q_req.re          = 1'b1;
                o_q_req.raddr       = r_elvl;
                o_slot_req.we_state = 1'b1;
                o_slot_req.we_prio  = (r_item.op == OP_CREATE);
                o_slot_req.waddr    = r_eslot;
                o_slot_req.wstate   = ST_READY;
                o_slot_req.wprio    = r_elvl;
            end
            S_EQ_WR: begin
                o_q_req.we    = 1'b1;
                o_q_req.waddr = r_elvl;
                o_q_req.wtail = r_eslot;
                if (!r_bitmap[r_elvl]) begin
                    // empty level: slot becomes head and tail
                    o_q_req.whead    = r_eslot;
                    n_bitmap[r_elvl] = 1'b1;
                end else begin
                    // link behind the old tail
                    o_q_req.whead      = i_q_rsp.head;
                    o_slot_req.we_next = 1'b1;
                    o_slot_req.waddr   = i_q_rsp.tail;
                    o_slot_req.wnext   = r_eslot;
                end
            end
            S_DQ_SEL: begin
                if (r_bitmap == '0) begin
                    n_cur_idle = 1'b1;
                end else begin
                    n_dlvl        = lowest_level(r_bitmap);
                    o_q_req.re    = 1'b1;
                    o_q_req.raddr = lowest_level(r_bitmap);
                end
            end
            S_DQ_HEAD: begin
                n_head  = i_q_rsp.head;
                n_qtail = i_q_rsp.tail;
                if (i_q_rsp.head == i_q_rsp.tail) begin
                    // last entry of the level: level goes empty
                    n_bitmap[r_dlvl]    = 1'b0;
                    o_slot_req.we_state = 1'b1;
                    o_slot_req.waddr    = i_q_rsp.head;
                    o_slot_req.wstate   = ST_RUNNING;
                    n_cur_slot          = i_q_rsp.head;
                    n_cur_idle          = 1'b0;
                end else begin
                    o_slot_req.re    = 1'b1;
                    o_slot_req.raddr = i_q_rsp.head;
                end
            end
            S_DQ_LINK: begin
                o_q_req.we          = 1'b1;
                o_q_req.waddr       = r_dlvl;
                o_q_req.whead       = i_slot_rsp.next;
                o_q_req.wtail       = r_qtail;
                o_slot_req.we_state = 1'b1;
                o_slot_req.waddr    = r_head;
                o_slot_req.wstate   = ST_RUNNING;
                n_cur_slot          = r_head;
                n_cur_idle          = 1'b0;
            end
            S_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                o_done = 1'b0;
            end
        endcase
    end

    // Result of the finished event
    always_comb begin
        o_result.running_task = r_cur_idle ? '0 : TASK_W'(r_cur_slot);
        o_result.running_idle = r_cur_idle;
        o_result.switched     = (r_item.op == OP_TICK) &&
                                ((r_was_idle != r_cur_idle) ||
                                 (!r_cur_idle && (r_was_slot != r_cur_slot)));
        o_result.status       = r_status;
    end

    assign o_ready = (r_state == S_IDLE);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cur_slot <= '0;
            r_cur_idle <= 1'b1;
            r_bitmap   <= '0;
            r_dflt     <= DEFAULT_PRIO_RST;
        end else begin
            r_state    <= n_state;
            r_cur_slot <= n_cur_slot;
            r_cur_idle <= n_cur_idle;
            r_bitmap   <= n_bitmap;
            if (i_cfg_we) begin
                r_dflt <= i_cfg_data;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_was_slot <= n_was_slot;
        r_was_idle <= n_was_idle;
        r_status   <= n_status;
        r_eslot    <= n_eslot;
        r_elvl     <= n_elvl;
        r_dlvl     <= n_dlvl;
        r_head     <= n_head;
        r_qtail    <= n_qtail;
    end

endmodule

// ===== rtl/bitmap_priority_task_scheduler.sv =====
// Flow: every event reads its slot word and checks it; create, unblock and a
// tick of a running task then do an enqueue pass, and a tick a dequeue pass.
// One event in flight, set by the read-then-write passes over the slot and
// queue memories: the next item is taken once the result is registered.
// Reset (synchronous, active low): idle runs, all queues empty, every slot
// free, default priority 16; no clearing pass, the block is ready at once.
// ----------------------------------------------------------------------------
// bitmap_priority_task_scheduler
// Run-queue scheduler with one linked FIFO per priority and a level bitmap.
// ----------------------------------------------------------------------------
module bitmap_priority_task_scheduler import bpts_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_in_item         i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output t_result          o_result
);

    t_slot_req slot_req;
    t_slot_rsp slot_rsp;
    t_q_req    q_req;
    t_q_rsp    q_rsp;
    logic      out_free;
    logic      done;
    t_result   result;
    logic      r_out_valid;
    t_result   r_out;

    bpts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .i_out_free (out_free),
        .o_done     (done),
        .o_result   (result),
        .o_slot_req (slot_req),
        .i_slot_rsp (slot_rsp),
        .o_q_req    (q_req),
        .i_q_rsp    (q_rsp)
    );

    bpts_slot_ram u_slot_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (slot_req),
        .o_rsp   (slot_rsp)
    );

    bpts_queue_ram u_queue_ram (
        .i_clk (i_clk),
        .i_req (q_req),
        .o_rsp (q_rsp)
    );

    // Output register: result waits here while the next item is taken
    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && out_free) begin
            r_out <= result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== rtl/bpts_checker.sv =====
// ----------------------------------------------------------------------------
// bpts_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_priority_task_scheduler_defines.svh"

module bpts_checker import bpts_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input t_result          o_result
);

    // A stalled result holds
    `BPTS_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_result))

    // One event in flight: ready drops after an input transfer
    `BPTS_ASSERT_NEXT(a_one_in_flight, i_valid && o_ready, !o_ready)

    // Out of reset: nothing pending, ready to take an item
    `BPTS_ASSERT_NEXT_RST(a_reset_state, !i_rst_n, !o_valid && o_ready)

    // Idle shows slot zero
    `BPTS_ASSERT_SAME(a_idle_slot, o_valid && o_result.running_idle,
                      o_result.running_task == '0)

endmodule

bind bitmap_priority_task_scheduler bpts_checker u_bpts_checker (.*);
